// ===== rtl/core/sle_pkg.sv =====
package sle_pkg;

  localparam int ACT_W = 2;
  localparam int VAL_W = 32;
  localparam int STAT_W = 3;
  localparam int POS_W = 4;
  localparam int CNT_W = 5;
  localparam int MAX_RESULTS = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_REMOVED   = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FOUND     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] removed_count;
    logic [CNT_W-1:0] list_length;
    logic             last_result;
  } result_t;

endpackage

// ===== rtl/core/sle_req_if.sv =====
interface sle_req_if;
  logic                                valid;
  logic                                ready;
  logic [sle_pkg::ACT_W-1:0]           action;
  logic signed [sle_pkg::VAL_W-1:0]    item_value;

  modport source (output valid, output action, output item_value, input ready);
  modport sink (input valid, input action, input item_value, output ready);
endinterface

// ===== rtl/core/sle_rsp_if.sv =====
interface sle_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [sle_pkg::STAT_W-1:0] status;
  logic [sle_pkg::POS_W-1:0]  position;
  logic [sle_pkg::CNT_W-1:0]  removed_count;
  logic [sle_pkg::CNT_W-1:0]  list_length;
  logic                       last_result;

  modport source (
    output valid, output status, output position, output removed_count,
    output list_length, output last_result, input ready
  );
  modport sink (
    input valid, input status, input position, input removed_count,
    input list_length, input last_result, output ready
  );
endinterface

// ===== rtl/core/sle_mem.sv =====
module sle_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [sle_pkg::VAL_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [sle_pkg::VAL_W-1:0] rd_data
);

  logic [sle_pkg::VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/sle_seq.sv =====
module sle_seq #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst,
  sle_req_if.sink           req,
  input  logic              emit_ready,
  output sle_pkg::result_t  emit
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  sle_pkg::state_t  state, state_next;
  sle_pkg::action_t act, act_next;
  logic [sle_pkg::VAL_W-1:0] value, value_next;
  logic [CW-1:0] occupied, occupied_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic [CW-1:0] keep, keep_next;
  logic [CW-1:0] occupied_inc;
  logic [AW-1:0] cmp_idx, cmp_idx_next;
  logic [AW-1:0] pend_pos, pend_pos_next;
  logic          data_vld, data_vld_next;
  logic          pend_vld, pend_vld_next;
  logic [sle_pkg::POS_W-1:0] nmatch, nmatch_next;

  logic                      wr_en, rd_en;
  logic [AW-1:0]             wr_addr, rd_addr;
  logic [sle_pkg::VAL_W-1:0] wr_data, rd_data;

  logic accept, match, emit_pend, advance, more, stop_early, scan_op;

  sle_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept       = req.valid && req.ready;
  assign scan_op      = req.action inside {sle_pkg::ACT_REMOVE, sle_pkg::ACT_SEARCH};
  assign match        = data_vld && (rd_data == value);
  assign emit_pend    = (act == sle_pkg::ACT_SEARCH) && match && pend_vld;
  assign advance      = !emit_pend || emit_ready;
  assign more         = rd_idx < occupied;
  assign stop_early   = emit_pend && (nmatch == sle_pkg::POS_W'(sle_pkg::MAX_RESULTS - 2));
  assign occupied_inc = occupied + CW'(1);

  always_comb begin
    state_next = state;
    case (state)
      sle_pkg::ST_IDLE: begin
        if (accept && scan_op) begin
          state_next = sle_pkg::ST_SCAN;
        end
      end
      sle_pkg::ST_SCAN: begin
        if (advance && (stop_early || !more)) begin
          state_next = sle_pkg::ST_FINISH;
        end
      end
      sle_pkg::ST_FINISH: begin
        if (emit_ready) begin
          state_next = sle_pkg::ST_IDLE;
        end
      end
      default: state_next = sle_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    act_next      = act;
    value_next    = value;
    occupied_next = occupied;
    rd_idx_next   = rd_idx;
    keep_next     = keep;
    cmp_idx_next  = cmp_idx;
    pend_pos_next = pend_pos;
    data_vld_next = data_vld;
    pend_vld_next = pend_vld;
    nmatch_next   = nmatch;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = rd_data;
    rd_en         = 1'b0;
    rd_addr       = rd_idx[AW-1:0];
    emit          = '0;
    req.ready     = 1'b0;
    case (state)
      sle_pkg::ST_IDLE: begin
        req.ready = emit_ready;
        if (accept) begin
          act_next      = sle_pkg::action_t'(req.action);
          value_next    = req.item_value;
          rd_idx_next   = '0;
          keep_next     = '0;
          nmatch_next   = '0;
          pend_vld_next = 1'b0;
          data_vld_next = 1'b0;
          if (req.action == sle_pkg::ACT_INSERT) begin
            emit.valid       = 1'b1;
            emit.last_result = 1'b1;
            if (occupied >= CW'(CAPACITY)) begin
              emit.status      = sle_pkg::STAT_FULL;
              emit.list_length = sle_pkg::CNT_W'(occupied);
            end else begin
              wr_en            = 1'b1;
              wr_addr          = occupied[AW-1:0];
              wr_data          = req.item_value;
              occupied_next    = occupied_inc;
              emit.status      = sle_pkg::STAT_INSERTED;
              emit.list_length = sle_pkg::CNT_W'(occupied_inc);
            end
          end
        end
      end
      sle_pkg::ST_SCAN: begin
        if (advance) begin
          if (data_vld && (act == sle_pkg::ACT_REMOVE) && !match) begin
            wr_en     = 1'b1;
            wr_addr   = keep[AW-1:0];
            wr_data   = rd_data;
            keep_next = keep + CW'(1);
          end
          if (emit_pend) begin
            emit.valid       = 1'b1;
            emit.status      = sle_pkg::STAT_FOUND;
            emit.position    = sle_pkg::POS_W'(pend_pos);
            emit.list_length = sle_pkg::CNT_W'(occupied);
            nmatch_next      = nmatch + sle_pkg::POS_W'(1);
          end
          if ((act == sle_pkg::ACT_SEARCH) && match) begin
            pend_vld_next = 1'b1;
            pend_pos_next = cmp_idx;
          end
          if (more && !stop_early) begin
            rd_en         = 1'b1;
            rd_idx_next   = rd_idx + CW'(1);
            cmp_idx_next  = rd_idx[AW-1:0];
            data_vld_next = 1'b1;
          end else begin
            data_vld_next = 1'b0;
          end
        end
      end
      sle_pkg::ST_FINISH: begin
        if (emit_ready) begin
          emit.valid       = 1'b1;
          emit.last_result = 1'b1;
          if (act == sle_pkg::ACT_REMOVE) begin
            occupied_next      = keep;
            emit.removed_count = sle_pkg::CNT_W'(occupied - keep);
            emit.list_length   = sle_pkg::CNT_W'(keep);
            emit.status        = (keep == occupied) ? sle_pkg::STAT_NOT_FOUND
                                                    : sle_pkg::STAT_REMOVED;
          end else begin
            emit.list_length = sle_pkg::CNT_W'(occupied);
            if (pend_vld) begin
              emit.status   = sle_pkg::STAT_FOUND;
              emit.position = sle_pkg::POS_W'(pend_pos);
            end else begin
              emit.status = sle_pkg::STAT_NOT_FOUND;
            end
          end
        end
      end
      default: begin
        emit = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sle_pkg::ST_IDLE;
      occupied <= '0;
      data_vld <= 1'b0;
      pend_vld <= 1'b0;
      nmatch   <= '0;
    end else begin
      state    <= state_next;
      occupied <= occupied_next;
      data_vld <= data_vld_next;
      pend_vld <= pend_vld_next;
      nmatch   <= nmatch_next;
    end
  end

  always_ff @(posedge clk) begin
    act      <= act_next;
    value    <= value_next;
    rd_idx   <= rd_idx_next;
    keep     <= keep_next;
    cmp_idx  <= cmp_idx_next;
    pend_pos <= pend_pos_next;
  end

endmodule

// ===== rtl/core/sequential_list_engine.sv =====
// Packed list of up to CAPACITY signed 32-bit words with insert, remove-all-equal and
// search. An insert is taken without a scan and yields one result word. A remove or a
// search walks the occupied entries through one registered memory read port and one
// 32-bit comparator, one entry per cycle while the result channel does not stall; a
// search emits one word per match (at most sixteen) or a single not-found word. The
// request channel is not ready while a scan is in progress or while the result
// register is full and not being drained. Entries are undefined after reset; only the
// length is cleared.
module sequential_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  sle_req_if.sink    req,
  sle_rsp_if.source  rsp
);

  sle_pkg::result_t emit;
  logic             emit_ready;
  logic             out_valid;

  assign emit_ready = !out_valid || rsp.ready;

  sle_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .emit_ready (emit_ready),
    .emit       (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit.valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      rsp.status        <= emit.status;
      rsp.position      <= emit.position;
      rsp.removed_count <= emit.removed_count;
      rsp.list_length   <= emit.list_length;
      rsp.last_result   <= emit.last_result;
    end
  end

  assign rsp.valid = out_valid;

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> (!out_valid || rsp.ready))
    else $error("Result word produced while the output register is occupied.");

  a_scan_blocks_req: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready &&
     (req.action == sle_pkg::ACT_REMOVE || req.action == sle_pkg::ACT_SEARCH))
    |=> !req.ready)
    else $error("Request channel ready right after a scan was started.");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != sle_pkg::STAT_FOUND) |-> rsp.last_result)
    else $error("Non-match result word not marked as the final word.");

endmodule

// ===== tb/sv/list_checker.sv =====
`timescale 1ns / 1ps

module list_checker
  import sle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  sle_req_if   req,
  sle_rsp_if   rsp,
  output int   errors,
  output int   expected_left,
  output int   words_checked
);

  localparam int LIST_DEPTH = 16;

  typedef struct {
    status_t          status;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] removed_count;
    logic [CNT_W-1:0] list_length;
    logic             last_result;
  } list_word_t;

  logic [VAL_W-1:0] list_entries [LIST_DEPTH];
  int unsigned      list_len = 0;
  list_word_t       expected_words [$];
  int               mismatch_count = 0;
  int               checked_count = 0;

  function automatic list_word_t make_word(status_t st, int unsigned pos, int unsigned removed,
                                           int unsigned len, logic last);
    list_word_t w;
    w.status        = st;
    w.position      = pos[POS_W-1:0];
    w.removed_count = removed[CNT_W-1:0];
    w.list_length   = len[CNT_W-1:0];
    w.last_result   = last;
    return w;
  endfunction

  function automatic void apply_list_op(action_t act, logic [VAL_W-1:0] value);
    int unsigned kept;
    int unsigned removed;
    int          hit_pos [$];
    case (act)
      ACT_INSERT: begin
        if (list_len >= LIST_DEPTH) begin
          expected_words.push_back(make_word(STAT_FULL, 0, 0, list_len, 1'b1));
        end else begin
          list_entries[list_len] = value;
          list_len++;
          expected_words.push_back(make_word(STAT_INSERTED, 0, 0, list_len, 1'b1));
        end
      end
      ACT_REMOVE: begin
        kept = 0;
        for (int i = 0; i < list_len; i++) begin
          if (list_entries[i] != value) begin
            list_entries[kept] = list_entries[i];
            kept++;
          end
        end
        removed  = list_len - kept;
        list_len = kept;
        if (removed == 0) begin
          expected_words.push_back(make_word(STAT_NOT_FOUND, 0, 0, list_len, 1'b1));
        end else begin
          expected_words.push_back(make_word(STAT_REMOVED, 0, removed, list_len, 1'b1));
        end
      end
      ACT_SEARCH: begin
        for (int i = 0; i < list_len && hit_pos.size() < MAX_RESULTS; i++) begin
          if (list_entries[i] == value) begin
            hit_pos.push_back(i);
          end
        end
        if (hit_pos.size() == 0) begin
          expected_words.push_back(make_word(STAT_NOT_FOUND, 0, 0, list_len, 1'b1));
        end
        foreach (hit_pos[k]) begin
          expected_words.push_back(make_word(STAT_FOUND, hit_pos[k], 0, list_len,
                                             k == hit_pos.size() - 1));
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_word();
    list_word_t exp_w;
    checked_count++;
    if (expected_words.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("unexpected result word: status %0d pos %0d removed %0d length %0d last %0b",
                 rsp.status, rsp.position, rsp.removed_count, rsp.list_length,
                 rsp.last_result);
      end
    end else begin
      exp_w = expected_words.pop_front();
      if (rsp.status !== exp_w.status || rsp.position !== exp_w.position ||
          rsp.removed_count !== exp_w.removed_count ||
          rsp.list_length !== exp_w.list_length || rsp.last_result !== exp_w.last_result) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("result mismatch: expected status %0d pos %0d removed %0d length %0d last %0b",
                   exp_w.status, exp_w.position, exp_w.removed_count, exp_w.list_length,
                   exp_w.last_result);
          $display("                 actual   status %0d pos %0d removed %0d length %0d last %0b",
                   rsp.status, rsp.position, rsp.removed_count, rsp.list_length,
                   rsp.last_result);
        end
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      list_len = 0;
      expected_words.delete();
    end else begin
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        apply_list_op(action_t'(req.action), req.item_value);
      end
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        check_word();
      end
    end
    errors        <= mismatch_count;
    expected_left <= expected_words.size();
    words_checked <= checked_count;
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sle_pkg::*;

  localparam int RANDOM_ITEMS = 320;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  sle_req_if req ();
  sle_rsp_if rsp ();

  int errors;
  int expected_left;
  int words_checked;

  sequential_list_engine #(
    .CAPACITY(16)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  list_checker u_checker (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .errors(errors),
    .expected_left(expected_left),
    .words_checked(words_checked)
  );

  bit               steady;
  bit               hold_wanted;
  int               items_sent;
  int               ops_sent [4];
  int               idle_cycles;
  logic [VAL_W-1:0] value_pool [6];

  function automatic int pick_gap();
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) begin
      return $urandom;
    end
    return value_pool[$urandom_range(0, 5)];
  endfunction

  function automatic action_t pick_action(int mode);
    int r;
    int ins_w;
    int rem_w;
    r = $urandom_range(0, 99);
    case (mode)
      0: begin
        ins_w = 70;
        rem_w = 10;
      end
      1: begin
        ins_w = 30;
        rem_w = 40;
      end
      default: begin
        ins_w = 45;
        rem_w = 20;
      end
    endcase
    if (r < 5) begin
      return ACT_NONE;
    end else if (r < 5 + ins_w) begin
      return ACT_INSERT;
    end else if (r < 5 + ins_w + rem_w) begin
      return ACT_REMOVE;
    end
    return ACT_SEARCH;
  endfunction

  task automatic send_word(action_t act, logic [VAL_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.action     <= act;
    req.item_value <= value;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    if (act != ACT_NONE) begin
      items_sent++;
    end
    ops_sent[act]++;
  endtask

  always @(posedge clk) begin
    if (rst || (req.valid === 1'b1 && req.ready === 1'b1) ||
        (rsp.valid === 1'b1 && rsp.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int on_len;
    int gap;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      rsp.ready <= 1'b1;
      on_len = $urandom_range(1, 24);
      repeat (on_len) @(posedge clk);
      if (hold_wanted) begin
        gap = HOLD_CYCLES;
        hold_wanted = 1'b0;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int mode;
    int random_start;
    req.valid      <= 1'b0;
    req.action     <= ACT_INSERT;
    req.item_value <= '0;
    steady      = 1'b0;
    hold_wanted = 1'b0;
    items_sent  = 0;
    foreach (ops_sent[i]) ops_sent[i] = 0;
    value_pool = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                   32'd5, 32'h5555_AAAA};
    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Operations on the empty list, then a mix of extremes and adjacent duplicates.
    send_word(ACT_SEARCH, 32'h0000_0000);
    send_word(ACT_REMOVE, 32'hFFFF_FFFF);
    send_word(ACT_NONE, 32'hDEAD_BEEF);
    send_word(ACT_INSERT, 32'h8000_0000);
    repeat (3) send_word(ACT_INSERT, 32'd7);
    send_word(ACT_INSERT, 32'h7FFF_FFFF);
    send_word(ACT_INSERT, 32'hFFFF_FFFF);
    send_word(ACT_INSERT, 32'h0000_0000);
    send_word(ACT_SEARCH, 32'd7);
    send_word(ACT_REMOVE, 32'd7);
    send_word(ACT_SEARCH, 32'h8000_0000);
    send_word(ACT_REMOVE, 32'h1234_5678);

    // Fill to capacity, overflow it, then find and drop the run of equal words.
    repeat (12) send_word(ACT_INSERT, 32'd5);
    send_word(ACT_INSERT, 32'hFFFF_FFFF);
    send_word(ACT_SEARCH, 32'd5);
    send_word(ACT_REMOVE, 32'd5);

    hold_wanted  = 1'b1;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      mode          = $urandom_range(0, 2);
      steady        = ($urandom_range(0, 3) == 0);
      value_pool[4] = $urandom;
      value_pool[5] = $urandom;
      repeat (30) send_word(pick_action(mode), pick_value());
    end
    req.valid <= 1'b0;
    steady = 1'b0;

    repeat (2) @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests: %0d insert, %0d remove, %0d search, %0d with the unused action.",
             items_sent + ops_sent[ACT_NONE], ops_sent[ACT_INSERT], ops_sent[ACT_REMOVE],
             ops_sent[ACT_SEARCH], ops_sent[ACT_NONE]);
    $display("Checked %0d result words against the predicted list, with %0d mismatches.",
             words_checked, errors);
    if (errors == 0 && expected_left == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sle_pkg.sv
rtl/core/sle_req_if.sv
rtl/core/sle_rsp_if.sv
rtl/core/sle_mem.sv
rtl/core/sle_seq.sv
rtl/core/sequential_list_engine.sv
tb/sv/list_checker.sv
tb/sv/tb.sv
